// ===== rtl/kbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyboard controller package
// Types, ring geometry and command codes that the keyboard controller shares.
// ----------------------------------------------------------------------------
package kbc_pkg;

    localparam int RING_DEPTH = 16;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [7:0]       byte_t;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_KEY   = 2'd2
    } kind_t;

    localparam byte_t PORT_DATA = 8'h60;
    localparam byte_t PORT_B    = 8'h61;
    localparam byte_t PORT_CMD  = 8'h64;

    // Controller commands written to port 64h.
    localparam byte_t CC_READ_CB       = 8'h20;
    localparam byte_t CC_WRITE_CB      = 8'h60;
    localparam byte_t CC_PASSWORD      = 8'hA6;
    localparam byte_t CC_AUX_DIS       = 8'hA7;
    localparam byte_t CC_AUX_EN        = 8'hA8;
    localparam byte_t CC_AUX_TEST      = 8'hA9;
    localparam byte_t CC_SELF_TEST     = 8'hAA;
    localparam byte_t CC_KBD_TEST      = 8'hAB;
    localparam byte_t CC_KBD_DIS       = 8'hAD;
    localparam byte_t CC_KBD_EN        = 8'hAE;
    localparam byte_t CC_READ_IN       = 8'hC0;
    localparam byte_t CC_READ_OUT      = 8'hD0;
    localparam byte_t CC_WRITE_OUT     = 8'hD1;
    localparam byte_t CC_WRITE_KBD_BUF = 8'hD2;
    localparam byte_t CC_WRITE_AUX_BUF = 8'hD3;
    localparam byte_t CC_WRITE_AUX     = 8'hD4;
    localparam byte_t CC_READ_TEST     = 8'hE0;
    localparam logic [3:0] CC_PULSE_HI = 4'hF;

    // Keyboard commands written to port 60h.
    localparam byte_t KB_SET_LED     = 8'hED;
    localparam byte_t KB_ECHO        = 8'hEE;
    localparam byte_t KB_SCAN_SET    = 8'hF0;
    localparam byte_t KB_READ_ID     = 8'hF2;
    localparam byte_t KB_STREAM_ON   = 8'hF4;
    localparam byte_t KB_DEFAULT_DIS = 8'hF5;
    localparam byte_t KB_SET_DEFAULT = 8'hF6;
    localparam byte_t KB_ALL_TYPEMAT = 8'hF7;
    localparam byte_t KB_BAT_RESTART = 8'hFF;

    // Reply bytes.
    localparam byte_t RSP_ZERO     = 8'h00;
    localparam byte_t RSP_SCAN_SET = 8'h02;
    localparam byte_t RSP_SELF_OK  = 8'h55;
    localparam byte_t RSP_ID_LO    = 8'h83;
    localparam byte_t RSP_BAT_OK   = 8'hAA;
    localparam byte_t RSP_ID_HI    = 8'hAB;
    localparam byte_t RSP_ACK      = 8'hFA;
    localparam byte_t RSP_RESEND   = 8'hFE;
    localparam byte_t RSP_NONE     = 8'hFF;

    // Command byte bits and masks.
    localparam int    CB_IRQ1_BIT  = 0;
    localparam int    CB_KBD_BIT   = 4;
    localparam int    CB_AUX_BIT   = 5;
    localparam byte_t CB_KBD_MASK  = 8'h10;
    localparam byte_t CB_AUX_MASK  = 8'h20;

    localparam byte_t PB_TOGGLE    = 8'h10;
    localparam byte_t PB_WR_MASK   = 8'h30;
    localparam int    PB_SPKR_BIT  = 1;

    localparam byte_t INPUT_PORT_RST  = 8'h90;
    localparam byte_t OUTPUT_PORT_RST = 8'h01;

    typedef struct packed {
        logic [1:0] kind;
        byte_t      port;
        byte_t      data;
    } item_t;

    typedef struct packed {
        byte_t read_data;
        logic  irq_pulse;
        logic  cpu_reset_pulse;
        byte_t output_port_state;
        logic  led_valid;
        byte_t led_value;
        logic  speaker_on;
        logic  aux_valid;
        byte_t aux_data;
    } result_t;

    typedef struct packed {
        logic  pop;
        logic  clear_idx;
        logic  push;
        byte_t push_byte;
        logic  push2;
        byte_t push2_byte;
        logic  key_wr;
        byte_t key_byte;
    } ring_op_t;

    typedef struct packed {
        logic  empty;
        logic  full;
        logic  pop_more;
        byte_t head_byte;
    } ring_stat_t;

endpackage

// ===== rtl/kbc_if.sv =====
// ----------------------------------------------------------------------------
// Keyboard controller channels
// Valid/ready interfaces for bus transactions in and result transactions out.
// ----------------------------------------------------------------------------
interface kbc_item_if
    import kbc_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    byte_t      port;
    byte_t      data;

    modport source (output valid, output kind, output port, output data, input ready);
    modport sink   (input valid, input kind, input port, input data, output ready);
endinterface

interface kbc_result_if
    import kbc_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t read_data;
    logic  irq_pulse;
    logic  cpu_reset_pulse;
    byte_t output_port_state;
    logic  led_valid;
    byte_t led_value;
    logic  speaker_on;
    logic  aux_valid;
    byte_t aux_data;

    modport source (
        output valid, output read_data, output irq_pulse, output cpu_reset_pulse,
        output output_port_state, output led_valid, output led_value,
        output speaker_on, output aux_valid, output aux_data, input ready
    );
    modport sink (
        input valid, input read_data, input irq_pulse, input cpu_reset_pulse,
        input output_port_state, input led_valid, input led_value,
        input speaker_on, input aux_valid, input aux_data, output ready
    );
endinterface

// ===== rtl/kbc_ring.sv =====
// ----------------------------------------------------------------------------
// Keyboard controller output ring
// Byte ring for the host: replies enter at the head, scan codes at the tail.
// ----------------------------------------------------------------------------
module kbc_ring
    import kbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ring_op_t   op,
    output ring_stat_t stat
);

    byte_t ring_reg  [RING_DEPTH];
    byte_t ring_next [RING_DEPTH];
    idx_t  head_reg, head_next;
    idx_t  tail_reg, tail_next;
    idx_t  head_base, tail_base, head_dec1, head_dec2;

    function automatic idx_t idx_inc(idx_t x);
        return (x == idx_t'(RING_DEPTH - 1)) ? '0 : idx_t'(x + 1'b1);
    endfunction

    function automatic idx_t idx_dec(idx_t x);
        return (x == '0) ? idx_t'(RING_DEPTH - 1) : idx_t'(x - 1'b1);
    endfunction

    always_comb
    begin
        stat.empty     = (head_reg == tail_reg);
        stat.full      = (idx_inc(tail_reg) == head_reg);
        stat.pop_more  = (idx_inc(head_reg) != tail_reg);
        stat.head_byte = ring_reg[head_reg];
    end

    always_comb
    begin
        head_base = op.clear_idx ? '0 : head_reg;
        tail_base = op.clear_idx ? '0 : tail_reg;
        head_dec1 = idx_dec(head_base);
        head_dec2 = idx_dec(head_dec1);

        if (op.pop && !stat.empty)
        begin
            head_next = idx_inc(head_reg);
        end
        else if (op.push2)
        begin
            head_next = head_dec2;
        end
        else if (op.push)
        begin
            head_next = head_dec1;
        end
        else
        begin
            head_next = head_base;
        end

        if (op.key_wr && !stat.full)
        begin
            tail_next = idx_inc(tail_reg);
        end
        else
        begin
            tail_next = tail_base;
        end

        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_next[i] = ring_reg[i];
            if (op.push && head_dec1 == idx_t'(i))
            begin
                ring_next[i] = op.push_byte;
            end
            else if (op.push2 && head_dec2 == idx_t'(i))
            begin
                ring_next[i] = op.push2_byte;
            end
            else if (op.key_wr && !stat.full && tail_reg == idx_t'(i))
            begin
                ring_next[i] = op.key_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            ring_reg <= ring_next;
        end
    end

    a_append_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (op.key_wr && !stat.full) |=> !stat.empty)
        else $error("ring empty after a scan code was appended");

    a_push_at_head: assert property (@(posedge clk) disable iff (!rst_n)
        (op.push && !op.push2) |=> (stat.head_byte == $past(op.push_byte)))
        else $error("pushed reply is not at the head of the ring");

    a_pop_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (op.pop && !stat.empty) |=> !stat.full)
        else $error("ring full right after a byte was read");

endmodule

// ===== rtl/kbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Keyboard controller command decoder
// Decodes one bus or key transaction, updates controller registers and forms
// the ring operation and the result.
// ----------------------------------------------------------------------------
module kbc_ctrl
    import kbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,
    input  item_t      cur,
    input  logic       cfg_we,
    input  byte_t      cfg_wdata,
    input  ring_stat_t stat,
    output ring_op_t   op,
    output result_t    res
);

    byte_t cb_reg, cb_next;
    logic  sys_reg, sys_next;
    byte_t pend_reg, pend_next;
    byte_t lkc_reg, lkc_next;
    byte_t outp_reg, outp_next;
    byte_t pb_reg, pb_next;
    byte_t inp_reg;
    ring_op_t op_c;

    always_comb
    begin
        cb_next   = cb_reg;
        sys_next  = sys_reg;
        pend_next = pend_reg;
        lkc_next  = lkc_reg;
        outp_next = outp_reg;
        pb_next   = pb_reg;
        op_c      = '0;
        res       = '0;

        case (cur.kind)
            KIND_READ:
            begin
                if (cur.port == PORT_DATA)
                begin
                    res.read_data = stat.head_byte;
                    op_c.pop      = 1'b1;
                    res.irq_pulse = !stat.empty && stat.pop_more && cb_reg[CB_IRQ1_BIT];
                end
                else if (cur.port == PORT_CMD)
                begin
                    res.read_data = {5'b0, sys_reg, 1'b0, !stat.empty};
                end
                else if (cur.port == PORT_B)
                begin
                    pb_next       = pb_reg ^ PB_TOGGLE;
                    res.read_data = pb_next;
                end
                else
                begin
                    res.read_data = RSP_NONE;
                end
            end
            KIND_WRITE:
            begin
                if (cur.port == PORT_CMD)
                begin
                    pend_next = cur.data;
                    case (cur.data)
                        CC_READ_CB:
                        begin
                            op_c.push = 1'b1;
                            op_c.push_byte = cb_reg;
                        end
                        CC_AUX_DIS: cb_next = cb_reg | CB_AUX_MASK;
                        CC_AUX_EN:  cb_next = cb_reg & ~CB_AUX_MASK;
                        CC_AUX_TEST, CC_KBD_TEST, CC_READ_TEST:
                        begin
                            op_c.push = 1'b1;
                            op_c.push_byte = RSP_ZERO;
                        end
                        CC_SELF_TEST:
                        begin
                            op_c.push = 1'b1;
                            op_c.push_byte = RSP_SELF_OK;
                        end
                        CC_KBD_DIS: cb_next = cb_reg | CB_KBD_MASK;
                        CC_KBD_EN:  cb_next = cb_reg & ~CB_KBD_MASK;
                        CC_READ_IN:
                        begin
                            op_c.push = 1'b1;
                            op_c.push_byte = inp_reg;
                        end
                        CC_READ_OUT:
                        begin
                            op_c.push = 1'b1;
                            op_c.push_byte = outp_reg;
                        end
                        default:
                        begin
                            if (cur.data[7:4] == CC_PULSE_HI && !cur.data[0])
                            begin
                                sys_next = 1'b1;
                                res.cpu_reset_pulse = 1'b1;
                            end
                        end
                    endcase
                end
                else if (cur.port == PORT_DATA)
                begin
                    pend_next = '0;
                    case (pend_reg)
                        CC_WRITE_CB:
                        begin
                            op_c.push = 1'b1;
                            op_c.push_byte = cb_reg;
                            cb_next = cur.data;
                        end
                        CC_WRITE_OUT:
                        begin
                            outp_next = cur.data;
                            res.cpu_reset_pulse = !cur.data[0];
                        end
                        CC_WRITE_KBD_BUF, CC_WRITE_AUX_BUF:
                        begin
                            op_c.push = 1'b1;
                            op_c.push_byte = cur.data;
                        end
                        CC_WRITE_AUX:
                        begin
                            if (!cb_reg[CB_AUX_BIT])
                            begin
                                res.aux_valid = 1'b1;
                                res.aux_data  = cur.data;
                            end
                            op_c.push = 1'b1;
                            op_c.push_byte = RSP_RESEND;
                        end
                        CC_PASSWORD:
                        begin
                            op_c.push = 1'b0;
                        end
                        default:
                        begin
                            op_c.push = 1'b1;
                            op_c.push_byte = RSP_ACK;
                            if (cur.data[7])
                            begin
                                lkc_next = cur.data;
                                case (cur.data)
                                    KB_ECHO: op_c.push_byte = KB_ECHO;
                                    KB_READ_ID:
                                    begin
                                        op_c.push_byte  = RSP_ID_HI;
                                        op_c.push2      = 1'b1;
                                        op_c.push2_byte = RSP_ID_LO;
                                    end
                                    KB_STREAM_ON, KB_DEFAULT_DIS, KB_SET_DEFAULT, KB_ALL_TYPEMAT:
                                    begin
                                        op_c.clear_idx = 1'b1;
                                    end
                                    KB_BAT_RESTART:
                                    begin
                                        op_c.push_byte = RSP_BAT_OK;
                                        sys_next = 1'b1;
                                    end
                                    default: op_c.push_byte = RSP_ACK;
                                endcase
                            end
                            else if (lkc_reg == KB_SET_LED)
                            begin
                                res.led_valid = 1'b1;
                                res.led_value = cur.data;
                            end
                            else if (lkc_reg == KB_SCAN_SET && cur.data == RSP_ZERO)
                            begin
                                op_c.push_byte = RSP_SCAN_SET;
                            end
                        end
                    endcase
                end
                else if (cur.port == PORT_B)
                begin
                    pb_next = cur.data & ~PB_WR_MASK;
                end
            end
            KIND_KEY:
            begin
                if (!cb_reg[CB_KBD_BIT])
                begin
                    op_c.key_wr   = 1'b1;
                    op_c.key_byte = cur.data;
                    res.irq_pulse = cb_reg[CB_IRQ1_BIT];
                end
            end
            default:
            begin
                res.read_data = '0;
            end
        endcase

        if (op_c.push && cb_reg[CB_IRQ1_BIT])
        begin
            res.irq_pulse = 1'b1;
        end
        res.output_port_state = outp_next;
        res.speaker_on        = pb_next[PB_SPKR_BIT];
    end

    assign op = go ? op_c : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cb_reg   <= '0;
            sys_reg  <= 1'b0;
            pend_reg <= '0;
            lkc_reg  <= '0;
            outp_reg <= OUTPUT_PORT_RST;
            pb_reg   <= '0;
            inp_reg  <= INPUT_PORT_RST;
        end
        else
        begin
            if (go)
            begin
                cb_reg   <= cb_next;
                sys_reg  <= sys_next;
                pend_reg <= pend_next;
                lkc_reg  <= lkc_next;
                outp_reg <= outp_next;
                pb_reg   <= pb_next;
            end
            if (cfg_we)
            begin
                inp_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== rtl/keyboard_controller_8042.sv =====
// ----------------------------------------------------------------------------
// Keyboard controller (8042 style)
// Bus port and key event front end with a host output ring.
// ----------------------------------------------------------------------------
// Usage:
// The item channel carries one transaction per bus read, bus write or key
// hit (kind, port, data). Every accepted transaction gives exactly one
// transaction on the result channel, in order.
// An accepted transaction is held in an input register; once the output
// register is free or its result is being taken, it is decoded against the
// controller registers and the ring, and the result is loaded into the output
// register, from which it is offered on the result channel. One transaction
// is taken every cycle while the receiver keeps up; the combinational decode
// between the input and output registers sets that rate.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more transaction; after that, ready drops
// until the result is taken.
// cfg_we/cfg_wdata write the byte answered by the read-input-port command;
// write it only while the block is idle.
// Reset zeroes ring, indexes and controller registers at once, except output
// port 01h and input port 90h; ready is high the first cycle after reset.
// ----------------------------------------------------------------------------
module keyboard_controller_8042
    import kbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    kbc_item_if.sink     item,
    kbc_result_if.source result,
    input  logic  cfg_we,
    input  byte_t cfg_wdata
);

    item_t      in_reg;
    logic       in_valid_reg, in_valid_next;
    result_t    res_reg, res_c;
    logic       res_valid_reg, res_valid_next;
    logic       go;
    ring_op_t   op;
    ring_stat_t stat;

    assign go         = in_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || go;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item.valid && item.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (go)
        begin
            in_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (go)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_reg.kind <= item.kind;
            in_reg.port <= item.port;
            in_reg.data <= item.data;
        end
        if (go)
        begin
            res_reg <= res_c;
        end
    end

    kbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .cur       (in_reg),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .op        (op),
        .res       (res_c)
    );

    kbc_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .stat  (stat)
    );

    assign result.valid             = res_valid_reg;
    assign result.read_data         = res_reg.read_data;
    assign result.irq_pulse         = res_reg.irq_pulse;
    assign result.cpu_reset_pulse   = res_reg.cpu_reset_pulse;
    assign result.output_port_state = res_reg.output_port_state;
    assign result.led_valid         = res_reg.led_valid;
    assign result.led_value         = res_reg.led_value;
    assign result.speaker_on        = res_reg.speaker_on;
    assign result.aux_valid         = res_reg.aux_valid;
    assign result.aux_data          = res_reg.aux_data;

    a_go_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> res_valid_reg)
        else $error("decoded transaction produced no result");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !go) |=> in_valid_reg)
        else $error("stalled transaction was lost from the input register");

    a_ring_idle_no_op: assert property (@(posedge clk) disable iff (!rst_n)
        !go |-> (op == '0))
        else $error("ring operation issued without a decoded transaction");

endmodule
